// ----- hw/rtl/gf2m_pkg.sv -----
package gf2m_pkg;

  // fixed widths of the channel words
  localparam int unsigned MODE_W = 3;
  localparam int unsigned OPND_W = 8;
  localparam int unsigned EXP_W  = 16;
  localparam int unsigned RES_W  = 8;
  localparam int unsigned POLY_W = 9;

  // x^8 + x^4 + x^3 + x^2 + 1
  localparam logic [POLY_W-1:0] POLY_RESET = 9'd285;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD = 3'd0,
    MODE_MUL = 3'd1,
    MODE_DIV = 3'd2,
    MODE_INV = 3'd3,
    MODE_POW = 3'd4
  } mode_e;

endpackage

// ----- hw/rtl/gf2m_in_if.sv -----
interface gf2m_in_if;
  import gf2m_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [OPND_W-1:0] operand_a;
  logic [OPND_W-1:0] operand_b;
  logic [EXP_W-1:0]  exponent;

  modport source (output valid, mode, operand_a, operand_b, exponent, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, exponent, output ready);
endinterface

// ----- hw/rtl/gf2m_out_if.sv -----
interface gf2m_out_if;
  import gf2m_pkg::*;

  logic             valid;
  logic             ready;
  logic [RES_W-1:0] result;
  logic             error;

  modport source (output valid, result, error, input ready);
  modport sink   (input valid, result, error, output ready);
endinterface

// ----- hw/rtl/gf2m_cfg_if.sv -----
interface gf2m_cfg_if;
  import gf2m_pkg::*;

  logic              valid;
  logic              ready;
  logic [POLY_W-1:0] field_polynomial;

  modport source (output valid, field_polynomial, input ready);
  modport sink   (input valid, field_polynomial, output ready);
endinterface

// ----- hw/rtl/gf2m_mul.sv -----
module gf2m_mul #(
  parameter int unsigned FIELD_WIDTH = 8
) (
  input  logic [FIELD_WIDTH-1:0] x_i,
  input  logic [FIELD_WIDTH-1:0] y_i,
  input  logic [FIELD_WIDTH-1:0] poly_i,
  output logic [FIELD_WIDTH-1:0] p_o
);

  // shift-and-add product, reduced whenever the top bit shifts out
  always_comb begin
    logic [FIELD_WIDTH-1:0] acc;
    logic [FIELD_WIDTH-1:0] sh;
    logic                   carry;
    acc = '0;
    sh  = x_i;
    for (int i = 0; i < FIELD_WIDTH; i++) begin
      if (y_i[i]) begin
        acc = acc ^ sh;
      end
      carry = sh[FIELD_WIDTH-1];
      sh    = {sh[FIELD_WIDTH-2:0], 1'b0} ^ (carry ? poly_i : '0);
    end
    p_o = acc;
  end

endmodule

// ----- hw/rtl/gf2m_arithmetic_unit.sv -----
// sequence: add goes straight to the write step, multiply through the multiply step,
//   inverse, divide and power by square-and-multiply, power after the exponent fold
// throughput: one word at a time; the next word is taken once the
//   result is moved into the output register; all steps share the single multiplier
// reset: clears sequencer and output valid, polynomial back to x^8+x^4+x^3+x^2+1
module gf2m_arithmetic_unit #(
  parameter int unsigned FIELD_WIDTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gf2m_cfg_if.sink   cfg_i,
  gf2m_in_if.sink    in_i,
  gf2m_out_if.source out_o
);
  import gf2m_pkg::*;

  localparam int unsigned W  = FIELD_WIDTH;
  localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;
  localparam int unsigned XW = (W > OPND_W) ? W : OPND_W;
  localparam int unsigned PW = (W > POLY_W) ? W : POLY_W;
  localparam int unsigned RW = (W > RES_W) ? W : RES_W;
  localparam logic [EXP_W-1:0] EMASK   = EXP_W'((32'd1 << W) - 32'd1);
  localparam logic [EXP_W-1:0] INV_EXP = EXP_W'((32'd1 << W) - 32'd2);
  localparam logic [CW-1:0]    TOP_BIT = CW'(W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_REDUCE,
    ST_SQR,
    ST_MULB,
    ST_FINAL,
    ST_WRITE
  } state_e;

  state_e            state_q, state_d;
  logic [POLY_W-1:0] poly_q;
  logic [W-1:0]      a_q, a_d;
  logic [W-1:0]      b_q, b_d;
  logic [W-1:0]      base_q, base_d;
  logic [W-1:0]      r_q, r_d;
  logic              err_q, err_d;
  logic              div_q, div_d;
  logic [EXP_W-1:0]  e_q, e_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              ovalid_q, ovalid_d;
  logic [RES_W-1:0]  ores_q, ores_d;
  logic              oerr_q, oerr_d;

  logic [XW-1:0] a_ext, b_ext;
  logic [W-1:0]  a_in, b_in;
  logic [PW-1:0] poly_ext;
  logic [W-1:0]  poly_w;
  logic [RW-1:0] r_ext;
  logic [W-1:0]  e_w;
  logic [W-1:0]  mx, my, mp;
  logic          in_fire, out_fire, out_free;

  // operand and polynomial width alignment
  assign a_ext    = XW'(in_i.operand_a);
  assign b_ext    = XW'(in_i.operand_b);
  assign a_in     = a_ext[W-1:0];
  assign b_in     = b_ext[W-1:0];
  assign poly_ext = PW'(poly_q);
  assign poly_w   = poly_ext[W-1:0];
  assign r_ext    = RW'(r_q);
  assign e_w      = e_q[W-1:0];

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign out_free = !ovalid_q || out_o.ready;

  assign in_i.ready   = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign out_o.valid  = ovalid_q;
  assign out_o.result = ores_q;
  assign out_o.error  = oerr_q;

  // shared multiplier operand select
  always_comb begin
    mx = r_q;
    my = r_q;
    unique case (state_q)
      ST_MUL:   begin mx = a_q; my = b_q;    end
      ST_MULB:  begin mx = r_q; my = base_q; end
      ST_FINAL: begin mx = r_q; my = a_q;    end
      default:  begin mx = r_q; my = r_q;    end
    endcase
  end

  gf2m_mul #(
    .FIELD_WIDTH(W)
  ) u_mul (
    .x_i   (mx),
    .y_i   (my),
    .poly_i(poly_w),
    .p_o   (mp)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    a_d      = a_q;
    b_d      = b_q;
    base_d   = base_q;
    r_d      = r_q;
    err_d    = err_q;
    div_d    = div_q;
    e_d      = e_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q && !out_fire;
    ores_d   = ores_q;
    oerr_d   = oerr_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          a_d    = a_in;
          b_d    = b_in;
          base_d = a_in;
          r_d    = '0;
          err_d  = 1'b0;
          div_d  = 1'b0;
          cnt_d  = TOP_BIT;
          e_d    = INV_EXP;
          state_d = ST_WRITE;
          case (in_i.mode)
            MODE_ADD: r_d = a_in ^ b_in;
            MODE_MUL: state_d = ST_MUL;
            MODE_DIV: begin
              if (b_in == '0) begin
                err_d = 1'b1;
              end else if (a_in != '0) begin
                base_d  = b_in;
                div_d   = 1'b1;
                r_d     = W'(1);
                state_d = ST_SQR;
              end
            end
            MODE_INV: begin
              if (a_in == '0) begin
                err_d = 1'b1;
              end else begin
                r_d     = W'(1);
                state_d = ST_SQR;
              end
            end
            MODE_POW: begin
              if (a_in == '0) begin
                r_d = (in_i.exponent == '0) ? W'(1) : '0;
              end else begin
                e_d     = in_i.exponent;
                state_d = ST_REDUCE;
              end
            end
            default: r_d = '0;
          endcase
        end
      end
      ST_MUL: begin
        r_d     = mp;
        state_d = ST_WRITE;
      end
      // fold exponent modulo 2^W-1
      ST_REDUCE: begin
        if (e_q > EMASK) begin
          e_d = EXP_W'((e_q & EMASK) + (e_q >> W));
        end else begin
          e_d     = (e_q == EMASK) ? '0 : e_q;
          r_d     = W'(1);
          state_d = ST_SQR;
        end
      end
      // square, then multiply by base when the exponent bit is set
      ST_SQR: begin
        r_d = mp;
        if (e_w[cnt_q]) begin
          state_d = ST_MULB;
        end else if (cnt_q == '0) begin
          state_d = div_q ? ST_FINAL : ST_WRITE;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = ST_SQR;
        end
      end
      ST_MULB: begin
        r_d = mp;
        if (cnt_q == '0) begin
          state_d = div_q ? ST_FINAL : ST_WRITE;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = ST_SQR;
        end
      end
      ST_FINAL: begin
        r_d     = mp;
        state_d = ST_WRITE;
      end
      // hand result to the output register
      ST_WRITE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ores_d   = r_ext[RES_W-1:0];
          oerr_d   = err_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      div_q    <= 1'b0;
      ores_q   <= '0;
      oerr_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      div_q    <= div_d;
      ores_q   <= ores_d;
      oerr_q   <= oerr_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    base_q <= base_d;
    r_q    <= r_d;
    err_q  <= err_d;
    e_q    <= e_d;
    cnt_q  <= cnt_d;
  end

  // field polynomial register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= POLY_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      poly_q <= cfg_i.field_polynomial;
    end
  end

  // an error word always carries a zero result
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.error |-> out_o.result == '0)
    else $error("error word with nonzero result");

  // the sequencer is busy right after taking a word
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("input taken while busy");

  // a new output word only comes from the write step
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == ST_WRITE))
    else $error("output loaded outside write step");

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gf2m_pkg::*;

  localparam int unsigned GROUP_ORDER = (1 << OPND_W) - 1;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned TAIL_CYCLES = 2 * OPND_W + 8;

  // one result word of the unit
  typedef struct packed {
    logic [RES_W-1:0] result;
    logic             error;
  } gf_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gf2m_cfg_if cfg_if ();
  gf2m_in_if  in_if ();
  gf2m_out_if out_if ();

  gf2m_arithmetic_unit #(
    .FIELD_WIDTH(OPND_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // predictor copy of the polynomial register
  logic [POLY_W-1:0] field_poly = POLY_RESET;

  gf_word_t    pending_results[$];
  int unsigned src_idle_pct   = 0;
  int unsigned snk_stall_pct  = 0;
  int unsigned sent_count     = 0;
  int unsigned checked_count  = 0;
  int unsigned poly_count     = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  always #5 clk_i = ~clk_i;

  // shift-and-add product, reduced whenever bit OPND_W comes up
  function automatic logic [OPND_W-1:0] field_mul(input logic [OPND_W-1:0] x,
                                                  input logic [OPND_W-1:0] y,
                                                  input logic [POLY_W-1:0] poly);
    logic [OPND_W:0]   shifted;
    logic [OPND_W-1:0] prod;
    shifted = {1'b0, x};
    prod    = '0;
    for (int i = 0; i < OPND_W; i++) begin
      if (y[i]) prod ^= shifted[OPND_W-1:0];
      shifted = shifted << 1;
      if (shifted[OPND_W]) shifted = {1'b0, shifted[OPND_W-1:0] ^ poly[OPND_W-1:0]};
    end
    return prod;
  endfunction

  // square-and-multiply from the top exponent bit down
  function automatic logic [OPND_W-1:0] field_pow(input logic [OPND_W-1:0] base,
                                                  input logic [EXP_W-1:0]  e,
                                                  input logic [POLY_W-1:0] poly);
    logic [OPND_W-1:0] acc;
    acc = OPND_W'(1);
    for (int i = EXP_W - 1; i >= 0; i--) begin
      acc = field_mul(acc, acc, poly);
      if (e[i]) acc = field_mul(acc, base, poly);
    end
    return acc;
  endfunction

  // expected result word for one operation under the current polynomial
  function automatic gf_word_t field_op_result(input logic [MODE_W-1:0] mode,
                                               input logic [OPND_W-1:0] a,
                                               input logic [OPND_W-1:0] b,
                                               input logic [EXP_W-1:0]  e);
    gf_word_t w;
    w = '0;
    case (mode)
      MODE_ADD: w.result = a ^ b;
      MODE_MUL: w.result = field_mul(a, b, field_poly);
      MODE_DIV: begin
        if (b == '0) w.error = 1'b1;
        else if (a != '0)
          w.result = field_mul(a, field_pow(b, EXP_W'(GROUP_ORDER - 1), field_poly), field_poly);
      end
      MODE_INV: begin
        if (a == '0) w.error = 1'b1;
        else w.result = field_pow(a, EXP_W'(GROUP_ORDER - 1), field_poly);
      end
      MODE_POW: begin
        if (a == '0) w.result = (e == '0) ? RES_W'(1) : '0;
        else w.result = field_pow(a, EXP_W'(e % GROUP_ORDER), field_poly);
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("mismatch on %s of result word %0d: expected %0h, got %0h",
               what, checked_count, want_v, got_v);
  endtask

  // send one word after a random hold-off, record its expectation on acceptance
  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [OPND_W-1:0] a,
                           input logic [OPND_W-1:0] b, input logic [EXP_W-1:0] e);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= mode;
    in_if.operand_a <= a;
    in_if.operand_b <= b;
    in_if.exponent  <= e;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results = {pending_results, field_op_result(mode, a, b, e)};
    sent_count++;
  endtask

  // hold the input off until every outstanding result is back
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_polynomial(input logic [POLY_W-1:0] poly);
    wait_for_drain();
    cfg_if.valid            <= 1'b1;
    cfg_if.field_polynomial <= poly;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    field_poly = poly;
    poly_count++;
  endtask

  // element biased toward zero, one and all ones
  function automatic logic [OPND_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return OPND_W'(1);
      2:       return '1;
      default: return OPND_W'($urandom);
    endcase
  endfunction

  // exponent biased toward zero and multiples of the group order
  function automatic logic [EXP_W-1:0] pick_exponent();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return EXP_W'(GROUP_ORDER * $urandom_range(1, 257));
      2:       return '1;
      3:       return EXP_W'($urandom_range(0, GROUP_ORDER));
      default: return EXP_W'($urandom);
    endcase
  endfunction

  task automatic send_random_word();
    logic [MODE_W-1:0] mode;
    if ($urandom_range(0, 99) < 8)
      mode = MODE_W'($urandom_range(int'(MODE_POW) + 1, (1 << MODE_W) - 1));
    else
      mode = MODE_W'($urandom_range(int'(MODE_ADD), int'(MODE_POW)));
    send_word(mode, pick_element(), pick_element(), pick_exponent());
  endtask

  // extremes, every operation and the zero special cases at reset polynomial
  task automatic test_directed_cases();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_word(MODE_ADD, '0, '0, '0);
    send_word(MODE_ADD, '1, '1, '1);
    send_word(MODE_ADD, 8'hAA, 8'h55, '0);
    send_word(MODE_MUL, '0, 8'h9C, '0);
    send_word(MODE_MUL, OPND_W'(1), 8'h9C, '0);
    send_word(MODE_MUL, '1, '1, '0);
    send_word(MODE_MUL, 8'h80, 8'h02, '0);
    // divide by zero, with and without a zero dividend, then nonzero divisors
    send_word(MODE_DIV, '0, '0, '0);
    send_word(MODE_DIV, 8'h05, '0, '0);
    send_word(MODE_DIV, '0, 8'h07, '0);
    send_word(MODE_DIV, '1, '1, '0);
    send_word(MODE_DIV, 8'h53, 8'hCA, '0);
    // invert zero and a few nonzero elements
    send_word(MODE_INV, '0, 8'h33, '1);
    send_word(MODE_INV, OPND_W'(1), '0, '0);
    send_word(MODE_INV, '1, '0, '0);
    send_word(MODE_INV, 8'h53, '1, '0);
    // zero base: only exponent zero gives one; then nonzero bases
    send_word(MODE_POW, '0, '1, '0);
    send_word(MODE_POW, '0, '0, EXP_W'(GROUP_ORDER));
    send_word(MODE_POW, '0, '0, EXP_W'(1));
    send_word(MODE_POW, 8'h02, '0, '0);
    send_word(MODE_POW, 8'h02, '0, EXP_W'(GROUP_ORDER));
    send_word(MODE_POW, 8'h03, '0, '1);
    send_word(MODE_POW, 8'h02, '0, EXP_W'(1));
    // unused mode codes
    for (int m = int'(MODE_POW) + 1; m < (1 << MODE_W); m++)
      send_word(MODE_W'(m), '1, '1, '1);
  endtask

  // extremes and assorted field polynomials, including reducible ones
  task automatic test_polynomial_sweep();
    logic [POLY_W-1:0] polys[8];
    polys = '{9'h000, 9'h1FF, 9'h100, 9'h11B, 9'h163,
              POLY_W'($urandom), POLY_W'($urandom), POLY_RESET};
    src_idle_pct  = 15;
    snk_stall_pct = 15;
    foreach (polys[i]) begin
      write_polynomial(polys[i]);
      repeat (20) send_random_word();
    end
  endtask

  // random words under each handshake pacing mix
  task automatic test_random_pacing();
    int unsigned src_pcts[4];
    int unsigned snk_pcts[4];
    src_pcts = '{0, 71, 0, 15};
    snk_pcts = '{0, 0, 71, 15};
    for (int p = 0; p < 4; p++) begin
      if ($urandom_range(0, 1) != 0) write_polynomial(POLY_W'($urandom));
      else write_polynomial(POLY_RESET);
      src_idle_pct  = src_pcts[p];
      snk_stall_pct = snk_pcts[p];
      repeat (130) send_random_word();
    end
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin : result_check
    gf_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result word: result %0h error %0b",
                   out_if.result, out_if.error);
      end else begin
        want = pending_results.pop_front();
        if (out_if.result !== want.result)
          report_mismatch("result", 32'(want.result), 32'(out_if.result));
        if (out_if.error !== want.error)
          report_mismatch("error", 32'(want.error), 32'(out_if.error));
      end
      checked_count++;
    end
  end

  // run time limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // reset, test sequence and final verdict
  initial begin
    rst_ni                  <= 1'b0;
    in_if.valid             <= 1'b0;
    in_if.mode              <= MODE_ADD;
    in_if.operand_a         <= '0;
    in_if.operand_b         <= '0;
    in_if.exponent          <= '0;
    cfg_if.valid            <= 1'b0;
    cfg_if.field_polynomial <= POLY_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_polynomial_sweep();
    test_random_pacing();

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      mismatch_count += pending_results.size();
      $display("%0d expected result words never arrived", pending_results.size());
    end
    $display("run covered %0d words and %0d results over %0d polynomial writes,",
             sent_count, checked_count, poly_count);
    $display("all operations, unused codes, zero operands and four pacing mixes");
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
